/* rtl/lbm_pkg.sv */
// Shared types, constants and helpers for the D2Q9 BGK collision core.
package lbm_pkg;

  localparam int NUM_DIR  = 9;
  localparam int POP_W    = 32;
  localparam int RATE_W   = 26;
  localparam int MOM_W    = 35;
  localparam int USQ_W    = 40;
  localparam int DIV_LAT  = 34;
  localparam int LANE_LAT = 9;

  localparam logic [RATE_W-1:0] RELAX_RESET = 26'd16777216;
  localparam logic [31:0] RECIP9 = 32'd3817748707;
  localparam logic [63:0] T_LIMIT = 64'h0000_0009_0000_0000;

  localparam int DIR_X   [NUM_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y   [NUM_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int OPPOSITE[NUM_DIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam int W_SHIFT [NUM_DIR] = '{22, 24, 24, 24, 24, 26, 26, 26, 26};

  typedef enum logic [0:0] {
    REG_RELAX_RATE   = 1'b0,
    REG_SAVE_MOMENTS = 1'b1
  } cfg_reg_t;

  typedef logic [NUM_DIR-1:0][POP_W-1:0] pops_t;

  typedef struct packed {
    logic              solid;
    logic signed [31:0] rho;
    pops_t             f;
  } node_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/lbm_d2q9_bgk_collision_core.sv */
// D2Q9 BGK collision core: moments, two divider lanes, nine direction lanes, merge.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  node in  | start / busy       | pop_in_0..pop_in_8, is_solid
//  result   | done (strobe)      | pop_out_0..8, density, vel_x, vel_y
//  config   | cfg_we             | cfg_index, cfg_data
//
// One node per cycle while busy is low, fully pipelined; done marks the result beat of
// each accepted node.
// Pipeline: input reg, moment reg, divider, 9-stage direction lanes, output reg.
// rst (synchronous) clears the pipeline valid bits and done and resets the config registers; busy is high in reset.
// The result side cannot stall; done is a one-cycle strobe.
module lbm_d2q9_bgk_collision_core import lbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [RATE_W-1:0]  cfg_data,
  input  logic signed [31:0] pop_in_0,
  input  logic signed [31:0] pop_in_1,
  input  logic signed [31:0] pop_in_2,
  input  logic signed [31:0] pop_in_3,
  input  logic signed [31:0] pop_in_4,
  input  logic signed [31:0] pop_in_5,
  input  logic signed [31:0] pop_in_6,
  input  logic signed [31:0] pop_in_7,
  input  logic signed [31:0] pop_in_8,
  input  logic               is_solid,
  output logic               done,
  output logic signed [31:0] pop_out_0,
  output logic signed [31:0] pop_out_1,
  output logic signed [31:0] pop_out_2,
  output logic signed [31:0] pop_out_3,
  output logic signed [31:0] pop_out_4,
  output logic signed [31:0] pop_out_5,
  output logic signed [31:0] pop_out_6,
  output logic signed [31:0] pop_out_7,
  output logic signed [31:0] pop_out_8,
  output logic signed [31:0] density,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y
);

  localparam int VLEN  = DIV_LAT + LANE_LAT + 1;
  localparam int TOTAL = DIV_LAT + LANE_LAT + 3;

  logic [RATE_W-1:0] relax_rate;
  logic              save_moments;

  logic              in_vld;
  logic              in_solid;
  pops_t             in_f;

  logic signed [35:0]      rho_sum;
  logic signed [MOM_W-1:0] mx_c, my_c, s1_mx, s1_my;
  node_t                   s1n;
  node_t                   dl1 [0:DIV_LAT-1];
  node_t                   dl2 [0:LANE_LAT-1];
  logic signed [31:0]      uxd [0:LANE_LAT-1];
  logic signed [31:0]      uyd [0:LANE_LAT-1];
  logic [VLEN-1:0]         vsr;

  logic signed [31:0] ux, uy;
  logic [31:0]        ax, ay;
  logic [63:0]        sqx, sqy;
  logic [USQ_W-1:0]   usq;
  pops_t              lane_out;
  pops_t              res_f;
  node_t              tail;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate   <= RELAX_RESET;
      save_moments <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELAX_RATE:   relax_rate   <= cfg_data;
        REG_SAVE_MOMENTS: save_moments <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else in_vld <= start && !busy;
    in_solid <= is_solid;
    in_f <= {pop_in_8, pop_in_7, pop_in_6, pop_in_5, pop_in_4,
             pop_in_3, pop_in_2, pop_in_1, pop_in_0};
  end

  always_comb begin
    rho_sum = '0;
    mx_c = '0;
    my_c = '0;
    for (int i = 0; i < NUM_DIR; i++) begin
      rho_sum = rho_sum + 36'($signed(in_f[i]));
      if (DIR_X[i] > 0) mx_c = mx_c + MOM_W'($signed(in_f[i]));
      if (DIR_X[i] < 0) mx_c = mx_c - MOM_W'($signed(in_f[i]));
      if (DIR_Y[i] > 0) my_c = my_c + MOM_W'($signed(in_f[i]));
      if (DIR_Y[i] < 0) my_c = my_c - MOM_W'($signed(in_f[i]));
    end
  end

  always_ff @(posedge clk) begin
    s1n.solid <= in_solid;
    s1n.rho   <= sat32(64'(rho_sum));
    s1n.f     <= in_f;
    s1_mx     <= mx_c;
    s1_my     <= my_c;
  end

  lbm_div u_div_x (.clk(clk), .num(s1_mx), .den(s1n.rho), .quo(ux));
  lbm_div u_div_y (.clk(clk), .num(s1_my), .den(s1n.rho), .quo(uy));

  always_ff @(posedge clk) begin
    if (rst) vsr <= '0;
    else vsr <= {vsr[VLEN-2:0], in_vld};
    dl1[0] <= s1n;
    for (int k = 1; k < DIV_LAT; k++) dl1[k] <= dl1[k-1];
    dl2[0] <= dl1[DIV_LAT-1];
    uxd[0] <= ux;
    uyd[0] <= uy;
    for (int k = 1; k < LANE_LAT; k++) begin
      dl2[k] <= dl2[k-1];
      uxd[k] <= uxd[k-1];
      uyd[k] <= uyd[k-1];
    end
  end

  assign ax  = ux[31] ? 32'(-ux) : 32'(ux);
  assign ay  = uy[31] ? 32'(-uy) : 32'(uy);
  assign sqx = {32'd0, ax} * {32'd0, ax};
  assign sqy = {32'd0, ay} * {32'd0, ay};

  always_ff @(posedge clk) begin
    usq <= USQ_W'(sqx >> 24) + USQ_W'(sqy >> 24);
  end

  for (genvar i = 0; i < NUM_DIR; i++) begin : g_lane
    lbm_lane #(.CX(DIR_X[i]), .CY(DIR_Y[i]), .SHIFT(W_SHIFT[i])) u_lane (
      .clk  (clk),
      .ux   (ux),
      .uy   (uy),
      .usq  (usq),
      .rho  (dl1[DIV_LAT-1].rho),
      .f    ($signed(dl1[DIV_LAT-1].f[i])),
      .rate (relax_rate),
      .pop  (lane_out[i])
    );
  end

  assign tail = dl2[LANE_LAT-1];

  always_comb begin
    for (int i = 0; i < NUM_DIR; i++) begin
      res_f[i] = tail.solid ? tail.f[OPPOSITE[i]] : lane_out[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vsr[VLEN-1];
    pop_out_0 <= res_f[0];
    pop_out_1 <= res_f[1];
    pop_out_2 <= res_f[2];
    pop_out_3 <= res_f[3];
    pop_out_4 <= res_f[4];
    pop_out_5 <= res_f[5];
    pop_out_6 <= res_f[6];
    pop_out_7 <= res_f[7];
    pop_out_8 <= res_f[8];
    if (save_moments && !tail.solid) begin
      density <= tail.rho;
      vel_x   <= uxd[LANE_LAT-1];
      vel_y   <= uyd[LANE_LAT-1];
    end else begin
      density <= '0;
      vel_x   <= '0;
      vel_y   <= '0;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##TOTAL done) else $error("result beat missing");

  a_solid_rest: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_solid |-> ##TOTAL pop_out_0 == $past(pop_in_0, TOTAL))
    else $error("solid rest population not passed through");

  a_solid_swap: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_solid |-> ##TOTAL pop_out_1 == $past(pop_in_3, TOTAL))
    else $error("bounce-back swap wrong");

  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    done && (density[31] || density == '0) |-> vel_x == '0 && vel_y == '0)
    else $error("velocity without positive density");

endmodule

/* rtl/lbm_div.sv */
// Pipelined restoring divider: saturated (num * 2^24) / den, zero unless den > 0, one quotient bit per stage.
module lbm_div import lbm_pkg::*; (
  input  logic                    clk,
  input  logic signed [MOM_W-1:0] num,
  input  logic signed [31:0]      den,
  output logic signed [31:0]      quo
);

  localparam int STEPS = 32;

  logic [31:0] rem   [0:STEPS];
  logic [31:0] qacc  [0:STEPS];
  logic [31:0] nbits [0:STEPS];
  logic [31:0] dd    [0:STEPS];
  logic        neg   [0:STEPS];
  logic        ovf   [0:STEPS];
  logic        pos   [0:STEPS];
  logic [MOM_W-1:0] mag;

  assign mag = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);

  always_ff @(posedge clk) begin
    rem[0]   <= 32'(mag >> 8);
    nbits[0] <= {mag[7:0], 24'd0};
    qacc[0]  <= '0;
    dd[0]    <= den;
    pos[0]   <= !den[31] && (den != '0);
    neg[0]   <= num[MOM_W-1];
    ovf[0]   <= {5'd0, mag} >= {den, 8'd0};
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [32:0] r2;
    logic [32:0] sub;
    logic        ge;
    assign r2  = {rem[k], nbits[k][31]};
    assign sub = r2 - {1'b0, dd[k]};
    assign ge  = r2 >= {1'b0, dd[k]};
    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? sub[31:0] : r2[31:0];
      qacc[k+1]  <= {qacc[k][30:0], ge};
      nbits[k+1] <= {nbits[k][30:0], 1'b0};
      dd[k+1]    <= dd[k];
      pos[k+1]   <= pos[k];
      neg[k+1]   <= neg[k];
      ovf[k+1]   <= ovf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!pos[STEPS]) begin
      quo <= '0;
    end else if (neg[STEPS]) begin
      if (ovf[STEPS] || qacc[STEPS] > 32'h8000_0000) quo <= 32'sh8000_0000;
      else quo <= -$signed(qacc[STEPS]);
    end else begin
      if (ovf[STEPS] || qacc[STEPS][31]) quo <= 32'sh7FFF_FFFF;
      else quo <= $signed(qacc[STEPS]);
    end
  end

endmodule

/* rtl/lbm_lane.sv */
// One direction lane: equilibrium, weight and relaxation pipeline.
module lbm_lane import lbm_pkg::*; #(
  parameter int CX    = 0,
  parameter int CY    = 0,
  parameter int SHIFT = 24
) (
  input  logic                    clk,
  input  logic signed [31:0]      ux,
  input  logic signed [31:0]      uy,
  input  logic [USQ_W-1:0]        usq,
  input  logic signed [31:0]      rho,
  input  logic signed [31:0]      f,
  input  logic [RATE_W-1:0]       rate,
  output logic signed [31:0]      pop
);

  logic signed [31:0] fd [1:8];
  logic signed [31:0] rho1, rho2;

  logic signed [33:0] cu_c, cu1;
  logic [33:0]        cu_mag;
  logic [65:0]        cu_sq;
  logic [40:0]        cu2;

  logic [44:0]        c9;
  logic [41:0]        u3;
  logic signed [47:0] pw;
  logic signed [31:0] poly2;

  logic signed [63:0] prod3;
  logic [63:0]        pmag, tsh;
  logic [35:0]        t4, t5;
  logic               ovf4, ovf5, ovf6, neg4, neg5, neg6;
  logic [63:0]        p5;
  logic [32:0]        qe5;
  logic [32:0]        qe6;
  logic [35:0]        r_full;
  logic [5:0]         r6;
  logic [33:0]        q;
  logic signed [31:0] feq7;
  logic signed [32:0] diff;
  logic signed [59:0] m8;

  always_comb begin
    cu_c = '0;
    if (CX > 0) cu_c = cu_c + 34'(ux);
    if (CX < 0) cu_c = cu_c - 34'(ux);
    if (CY > 0) cu_c = cu_c + 34'(uy);
    if (CY < 0) cu_c = cu_c - 34'(uy);
    cu_mag = cu_c[33] ? 34'(-cu_c) : 34'(cu_c);
    cu_sq  = {33'd0, cu_mag[32:0]} * {33'd0, cu_mag[32:0]};
  end

  always_comb begin
    c9 = 45'(({4'd0, cu2} * 45'd9) >> 1);
    u3 = 42'(({2'd0, usq} * 42'd3) >> 1);
    pw = 48'sd16777216 + 48'(cu1) * 48'sd3 + $signed(48'(c9)) - $signed(48'(u3));
  end

  assign pmag   = prod3[63] ? 64'(-prod3) : 64'(prod3);
  assign tsh    = pmag >> SHIFT;
  assign qe5    = p5[63:31];
  assign r_full = t5 - 36'(qe5) * 36'd9;

  always_comb begin
    q = 34'(qe6) + 34'(r6 >= 6'd9) + 34'(r6 >= 6'd18) + 34'(r6 >= 6'd27)
      + 34'(r6 >= 6'd36) + 34'(r6 >= 6'd45);
  end

  assign diff = 33'(feq7) - 33'(fd[7]);

  always_ff @(posedge clk) begin
    fd[1] <= f;
    for (int k = 2; k <= 8; k++) fd[k] <= fd[k-1];
    rho1 <= rho;
    rho2 <= rho1;
    cu1  <= cu_c;
    cu2  <= cu_sq[64:24];
    poly2 <= sat32(64'(pw));
    prod3 <= 64'(rho2) * 64'(poly2);
    t4   <= tsh[35:0];
    ovf4 <= tsh >= T_LIMIT;
    neg4 <= prod3[63];
    p5   <= {32'd0, t4[35:4]} * {32'd0, RECIP9};
    t5   <= t4;
    ovf5 <= ovf4;
    neg5 <= neg4;
    qe6  <= qe5;
    r6   <= r_full[5:0];
    ovf6 <= ovf5;
    neg6 <= neg5;
    if (ovf6) begin
      feq7 <= neg6 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg6) begin
      feq7 <= (q > 34'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      feq7 <= (q > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    m8  <= 60'($signed({1'b0, rate})) * 60'(diff);
    pop <= sat32(64'(fd[8]) + 64'(m8 >>> 24));
  end

endmodule
